@@ src/tdf_pkg.sv @@
`timescale 1ns / 1ps
package tdf_pkg;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_BUILD  = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FAIL   = 2'd1;
    localparam logic [1:0] ST_BADQ   = 2'd2;

    localparam logic [1:0] MIRROR_H     = 2'd1;
    localparam logic [1:0] MIRROR_V     = 2'd2;
    localparam logic [1:0] MIRROR_HV    = 2'd3;
    localparam logic [1:0] TILE_NO_FLIP = 2'd0;

    localparam logic [2:0] CFG_SNAP_W  = 3'd0;
    localparam logic [2:0] CFG_SNAP_H  = 3'd1;
    localparam logic [2:0] CFG_OFF_X   = 3'd2;
    localparam logic [2:0] CFG_OFF_Y   = 3'd3;
    localparam logic [2:0] CFG_IMG_W   = 3'd4;
    localparam logic [2:0] CFG_IMG_H   = 3'd5;
    localparam logic [2:0] CFG_FLIP_X  = 3'd6;
    localparam logic [2:0] CFG_FLIP_Y  = 3'd7;

    typedef struct packed {
        logic wr_next;
        logic wr_prev;
        logic wr_flip;
    } t_link_we;

    // {more, mode}: the mirror mode tried after the given one
    function automatic logic [2:0] next_mode(input logic [1:0] mode,
                                             input logic fx, input logic fy);
        logic [2:0] res;
        res = {1'b0, TILE_NO_FLIP};
        case (mode)
            TILE_NO_FLIP: begin
                if (fy)
                    res = {1'b1, MIRROR_V};
                else if (fx)
                    res = {1'b1, MIRROR_H};
            end
            MIRROR_V: begin
                if (fx)
                    res = {1'b1, MIRROR_H};
            end
            MIRROR_H: begin
                if (fx && fy)
                    res = {1'b1, MIRROR_HV};
            end
            default: res = {1'b0, TILE_NO_FLIP};
        endcase
        return res;
    endfunction

endpackage

@@ src/tile_dedup_with_flips_unit.sv @@
`timescale 1ns / 1ps
// Tile deduplication with mirroring. Each transfer carries one request in
// tuser (load pixel, build, query) and gives exactly one result. A load or
// unknown request is answered from the idle state, a query after one link
// memory read. A build first runs two 9-bit divisions and a size check,
// then writes the n tile links at one per cycle, then for every tile t and
// every allowed mirror mode walks the earlier tiles r < t: for each it
// reads the ring link from the link memory, and for an eligible tile it
// compares pixels through the two read ports of the pixel memory, stopping
// at the first mismatch; a join then writes the links in S_J1, S_J2, S_J3.
// Pixel and link memories come up undefined and need no clearing pass.
module tile_dedup_with_flips_unit
    import tdf_pkg::*;
#(
    parameter int MAX_IMAGE_SIDE = 256,
    parameter int MAX_TILES      = 1024,
    parameter int PIXEL_BITS     = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // pixel_x[7:0], pixel_y[15:8], pixel_value[23:16], tile_index[33:24]
    input  logic [39:0] i_s_tdata,
    // req_type[1:0]
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // status[1:0], unique_count[12:2], tiles_across[21:13], tiles_down[30:22],
    // next_tile[40:31], prev_tile[50:41], flip_code[52:51]
    output logic [55:0] o_m_tdata,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [8:0]  i_cfg_wdata
);

    localparam int SIDE_BITS  = (MAX_IMAGE_SIDE >= 256) ? 8 : $clog2(MAX_IMAGE_SIDE);
    localparam int LINK_DEPTH = (MAX_TILES < 65536) ? MAX_TILES : 65536;
    localparam int TW         = $clog2(LINK_DEPTH);
    localparam int CW         = $clog2(LINK_DEPTH + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_QRY  = 4'd1;
    localparam logic [3:0] S_DIVC = 4'd2;
    localparam logic [3:0] S_DIVR = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_FIT  = 4'd5;
    localparam logic [3:0] S_INIT = 4'd6;
    localparam logic [3:0] S_RRD  = 4'd7;
    localparam logic [3:0] S_RCHK = 4'd8;
    localparam logic [3:0] S_CMP  = 4'd9;
    localparam logic [3:0] S_J1   = 4'd10;
    localparam logic [3:0] S_J2   = 4'd11;
    localparam logic [3:0] S_J3   = 4'd12;

    // input fields
    logic [1:0] s_req;
    logic [7:0] s_px, s_py, s_pv;
    logic [9:0] s_ti;
    assign s_req = i_s_tuser;
    assign s_px  = i_s_tdata[7:0];
    assign s_py  = i_s_tdata[15:8];
    assign s_pv  = i_s_tdata[23:16];
    assign s_ti  = i_s_tdata[33:24];

    // configuration
    logic [8:0] r_sw, r_sh, r_iw, r_ih;
    logic [7:0] r_ox, r_oy;
    logic       r_fx, r_fy;

    // map state
    logic          r_map_valid;
    logic [8:0]    r_map_cols, n_map_cols, r_map_rows, n_map_rows;
    logic [CW-1:0] r_map_n, n_map_n, r_distinct, n_distinct;
    logic          n_map_valid;

    // build state
    logic [3:0]    r_state, n_state;
    logic [8:0]    r_cols, n_cols, r_rows, n_rows;
    logic [17:0]   r_prod, n_prod;
    logic [CW-1:0] r_n, n_n, r_t, n_t, r_r, n_r, r_count, n_count;
    logic [8:0]    r_tcol, n_tcol, r_tx, n_tx, r_ty, n_ty;
    logic [8:0]    r_rcol, n_rcol, r_rx, n_rx, r_ry, n_ry;
    logic [1:0]    r_mode, n_mode, r_flipr, n_flipr;
    logic [TW-1:0] r_last, n_last;
    logic [8:0]    r_cx, n_cx, r_cy, n_cy;
    logic          r_issue, n_issue, r_pv, n_pv, r_plast, n_plast;
    logic          r_qok, n_qok;

    // result register
    logic       r_ov, n_ov;
    logic [1:0] r_o_status, n_o_status, r_o_flip, n_o_flip;
    logic [10:0] r_o_unique, n_o_unique;
    logic [8:0] r_o_across, n_o_across, r_o_down, n_o_down;
    logic [9:0] r_o_next, n_o_next, r_o_prev, n_o_prev;

    // memories and divider
    logic                        pix_we;
    logic [2*SIDE_BITS-1:0]      pix_waddr, pix_raddr_a, pix_raddr_b;
    logic [PIXEL_BITS-1:0]       pix_qa, pix_qb;
    t_link_we                    lk_we;
    logic [TW-1:0]               lk_waddr, lk_next_d, lk_prev_d, lk_raddr;
    logic [1:0]                  lk_flip_d;
    logic [TW-1:0]               lk_next_q, lk_prev_q;
    logic [1:0]                  lk_flip_q;
    logic                        div_start, div_done;
    logic [8:0]                  div_dividend, div_divisor, div_q;

    logic       accept;
    logic [8:0] iw_sat, ih_sat;
    logic       pre_fail;
    logic       ta_wrap, ra_wrap;
    logic [8:0] ta_col, ta_x, ta_y, ra_col, ra_x, ra_y;
    logic [8:0] ax, ay, bx, by;
    logic       cmp_last;
    logic [2:0] nm;
    logic [CW-1:0] cnt_inc;

    assign o_s_tready = (r_state == S_IDLE) && (!r_ov || i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;

    assign iw_sat   = (32'(r_iw) > MAX_IMAGE_SIDE) ? 9'(MAX_IMAGE_SIDE) : r_iw;
    assign ih_sat   = (32'(r_ih) > MAX_IMAGE_SIDE) ? 9'(MAX_IMAGE_SIDE) : r_ih;
    assign pre_fail = (r_sw == 9'd0) || (r_sh == 9'd0) ||
                      (iw_sat <= {1'b0, r_ox}) || (ih_sat <= {1'b0, r_oy});

    // raster stepping of the candidate and reference tile corners
    assign ta_wrap = (r_tcol == r_cols - 9'd1);
    assign ta_col  = ta_wrap ? 9'd0 : r_tcol + 9'd1;
    assign ta_x    = ta_wrap ? {1'b0, r_ox} : r_tx + r_sw;
    assign ta_y    = ta_wrap ? r_ty + r_sh : r_ty;
    assign ra_wrap = (r_rcol == r_cols - 9'd1);
    assign ra_col  = ra_wrap ? 9'd0 : r_rcol + 9'd1;
    assign ra_x    = ra_wrap ? {1'b0, r_ox} : r_rx + r_sw;
    assign ra_y    = ra_wrap ? r_ry + r_sh : r_ry;

    // the candidate is read mirrored, the reference straight
    assign ax = r_rx + r_cx;
    assign ay = r_ry + r_cy;
    assign bx = r_tx + (r_mode[0] ? r_sw - 9'd1 - r_cx : r_cx);
    assign by = r_ty + (r_mode[1] ? r_sh - 9'd1 - r_cy : r_cy);
    assign cmp_last = (r_cx == r_sw - 9'd1) && (r_cy == r_sh - 9'd1);

    assign pix_raddr_a = {ay[SIDE_BITS-1:0], ax[SIDE_BITS-1:0]};
    assign pix_raddr_b = {by[SIDE_BITS-1:0], bx[SIDE_BITS-1:0]};
    assign pix_waddr   = {s_py[SIDE_BITS-1:0], s_px[SIDE_BITS-1:0]};
    assign pix_we      = accept && (s_req == REQ_LOAD) &&
                         (32'(s_px) < MAX_IMAGE_SIDE) && (32'(s_py) < MAX_IMAGE_SIDE);

    assign nm      = next_mode(r_mode, r_fx, r_fy);
    assign cnt_inc = r_count + 1'b1;

    assign div_dividend = (r_state == S_IDLE) ? iw_sat - {1'b0, r_ox}
                                              : ih_sat - {1'b0, r_oy};
    assign div_divisor  = (r_state == S_IDLE) ? r_sw : r_sh;
    assign div_start    = (accept && (s_req == REQ_BUILD) && !pre_fail) ||
                          ((r_state == S_DIVC) && div_done && (div_q != 9'd0));

    assign lk_raddr = (r_state == S_IDLE) ? TW'(s_ti) : r_r[TW-1:0];

    always_comb begin
        lk_we     = '0;
        lk_waddr  = r_r[TW-1:0];
        lk_next_d = r_r[TW-1:0];
        lk_prev_d = r_r[TW-1:0];
        lk_flip_d = TILE_NO_FLIP;
        case (r_state)
            S_INIT: begin
                lk_we = '{wr_next: 1'b1, wr_prev: 1'b1, wr_flip: 1'b1};
            end
            S_J1: begin
                lk_we     = '{wr_next: 1'b1, wr_prev: 1'b1, wr_flip: 1'b1};
                lk_waddr  = r_t[TW-1:0];
                lk_prev_d = r_last;
                lk_flip_d = r_flipr ^ r_mode;
            end
            S_J2: begin
                lk_we.wr_prev = 1'b1;
                lk_prev_d     = r_t[TW-1:0];
            end
            S_J3: begin
                lk_we.wr_next = 1'b1;
                lk_waddr      = r_last;
                lk_next_d     = r_t[TW-1:0];
            end
            default: lk_we = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_map_valid = r_map_valid;
        n_map_cols = r_map_cols;
        n_map_rows = r_map_rows;
        n_map_n = r_map_n;
        n_distinct = r_distinct;
        n_cols = r_cols;
        n_rows = r_rows;
        n_prod = r_prod;
        n_n = r_n;
        n_t = r_t;
        n_r = r_r;
        n_count = r_count;
        n_tcol = r_tcol;
        n_tx = r_tx;
        n_ty = r_ty;
        n_rcol = r_rcol;
        n_rx = r_rx;
        n_ry = r_ry;
        n_mode = r_mode;
        n_flipr = r_flipr;
        n_last = r_last;
        n_cx = r_cx;
        n_cy = r_cy;
        n_issue = r_issue;
        n_pv = 1'b0;
        n_plast = r_plast;
        n_qok = r_qok;
        n_ov = r_ov && !i_m_tready;
        n_o_status = r_o_status;
        n_o_unique = r_o_unique;
        n_o_across = r_o_across;
        n_o_down = r_o_down;
        n_o_next = r_o_next;
        n_o_prev = r_o_prev;
        n_o_flip = r_o_flip;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_o_next = '0;
                    n_o_prev = '0;
                    n_o_flip = '0;
                    n_o_status = ST_OK;
                    n_o_unique = 11'(r_distinct);
                    n_o_across = r_map_cols;
                    n_o_down = r_map_rows;
                    if (s_req == REQ_BUILD) begin
                        // a build drops the old map up front
                        n_map_valid = 1'b0;
                        n_map_cols = '0;
                        n_map_rows = '0;
                        n_map_n = '0;
                        n_distinct = '0;
                        if (pre_fail) begin
                            n_ov = 1'b1;
                            n_o_status = ST_FAIL;
                            n_o_unique = '0;
                            n_o_across = '0;
                            n_o_down = '0;
                        end else begin
                            n_state = S_DIVC;
                        end
                    end else if (s_req == REQ_QUERY) begin
                        n_qok = r_map_valid && (32'(s_ti) < 32'(r_map_n)) &&
                                (32'(s_ti) < MAX_TILES);
                        n_state = S_QRY;
                    end else begin
                        n_ov = 1'b1;
                    end
                end
            end
            S_QRY: begin
                n_ov = 1'b1;
                n_state = S_IDLE;
                if (r_qok) begin
                    n_o_next = 10'(lk_next_q);
                    n_o_prev = 10'(lk_prev_q);
                    n_o_flip = lk_flip_q;
                end else begin
                    n_o_status = ST_BADQ;
                end
            end
            S_DIVC: begin
                if (div_done) begin
                    n_cols = div_q;
                    n_state = (div_q == 9'd0) ? S_IDLE : S_DIVR;
                    if (div_q == 9'd0) begin
                        n_ov = 1'b1;
                        n_o_status = ST_FAIL;
                        n_o_unique = '0;
                        n_o_across = '0;
                        n_o_down = '0;
                    end
                end
            end
            S_DIVR: begin
                if (div_done) begin
                    n_rows = div_q;
                    n_state = (div_q == 9'd0) ? S_IDLE : S_MUL;
                    if (div_q == 9'd0) begin
                        n_ov = 1'b1;
                        n_o_status = ST_FAIL;
                        n_o_unique = '0;
                        n_o_across = '0;
                        n_o_down = '0;
                    end
                end
            end
            S_MUL: begin
                n_prod = r_cols * r_rows;
                n_state = S_FIT;
            end
            S_FIT: begin
                if (32'(r_prod) > MAX_TILES) begin
                    n_state = S_IDLE;
                    n_ov = 1'b1;
                    n_o_status = ST_FAIL;
                    n_o_unique = '0;
                    n_o_across = '0;
                    n_o_down = '0;
                end else begin
                    n_n = CW'(r_prod);
                    n_r = '0;
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                n_r = r_r + 1'b1;
                if (r_r == r_n - 1'b1) begin
                    n_count = CW'(1);
                    if (r_n == CW'(1)) begin
                        n_state = S_IDLE;
                        n_map_valid = 1'b1;
                        n_map_cols = r_cols;
                        n_map_rows = r_rows;
                        n_map_n = r_n;
                        n_distinct = CW'(1);
                        n_ov = 1'b1;
                        n_o_status = ST_OK;
                        n_o_unique = 11'd1;
                        n_o_across = r_cols;
                        n_o_down = r_rows;
                    end else begin
                        n_t = CW'(1);
                        n_tcol = (r_cols == 9'd1) ? 9'd0 : 9'd1;
                        n_tx = (r_cols == 9'd1) ? {1'b0, r_ox} : {1'b0, r_ox} + r_sw;
                        n_ty = (r_cols == 9'd1) ? {1'b0, r_oy} + r_sh : {1'b0, r_oy};
                        n_mode = TILE_NO_FLIP;
                        n_r = '0;
                        n_rcol = '0;
                        n_rx = {1'b0, r_ox};
                        n_ry = {1'b0, r_oy};
                        n_state = S_RRD;
                    end
                end
            end
            S_RRD: begin
                if (r_r == r_t) begin
                    n_r = '0;
                    n_rcol = '0;
                    n_rx = {1'b0, r_ox};
                    n_ry = {1'b0, r_oy};
                    if (nm[2]) begin
                        n_mode = nm[1:0];
                    end else begin
                        // no ring took this tile: it opens its own
                        n_count = cnt_inc;
                        n_mode = TILE_NO_FLIP;
                        n_t = r_t + 1'b1;
                        n_tcol = ta_col;
                        n_tx = ta_x;
                        n_ty = ta_y;
                        if (r_t + 1'b1 == r_n) begin
                            n_state = S_IDLE;
                            n_map_valid = 1'b1;
                            n_map_cols = r_cols;
                            n_map_rows = r_rows;
                            n_map_n = r_n;
                            n_distinct = cnt_inc;
                            n_ov = 1'b1;
                            n_o_status = ST_OK;
                            n_o_unique = 11'(cnt_inc);
                            n_o_across = r_cols;
                            n_o_down = r_rows;
                        end
                    end
                end else begin
                    n_state = S_RCHK;
                end
            end
            S_RCHK: begin
                if (CW'(lk_prev_q) > r_r) begin
                    n_r = r_r + 1'b1;
                    n_rcol = ra_col;
                    n_rx = ra_x;
                    n_ry = ra_y;
                    n_state = S_RRD;
                end else begin
                    n_last = lk_prev_q;
                    n_flipr = lk_flip_q;
                    n_cx = '0;
                    n_cy = '0;
                    n_issue = 1'b1;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_issue) begin
                    n_pv = 1'b1;
                    n_plast = cmp_last;
                    if (cmp_last) begin
                        n_issue = 1'b0;
                    end else if (r_cx == r_sw - 9'd1) begin
                        n_cx = '0;
                        n_cy = r_cy + 9'd1;
                    end else begin
                        n_cx = r_cx + 9'd1;
                    end
                end
                if (r_pv && (pix_qa != pix_qb)) begin
                    n_issue = 1'b0;
                    n_pv = 1'b0;
                    n_r = r_r + 1'b1;
                    n_rcol = ra_col;
                    n_rx = ra_x;
                    n_ry = ra_y;
                    n_state = S_RRD;
                end else if (r_pv && r_plast) begin
                    n_issue = 1'b0;
                    n_pv = 1'b0;
                    n_state = S_J1;
                end
            end
            S_J1: n_state = S_J2;
            S_J2: n_state = S_J3;
            S_J3: begin
                n_mode = TILE_NO_FLIP;
                n_r = '0;
                n_rcol = '0;
                n_rx = {1'b0, r_ox};
                n_ry = {1'b0, r_oy};
                n_t = r_t + 1'b1;
                n_tcol = ta_col;
                n_tx = ta_x;
                n_ty = ta_y;
                n_state = S_RRD;
                if (r_t + 1'b1 == r_n) begin
                    n_state = S_IDLE;
                    n_map_valid = 1'b1;
                    n_map_cols = r_cols;
                    n_map_rows = r_rows;
                    n_map_n = r_n;
                    n_distinct = r_count;
                    n_ov = 1'b1;
                    n_o_status = ST_OK;
                    n_o_unique = 11'(r_count);
                    n_o_across = r_cols;
                    n_o_down = r_rows;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sw <= 9'd8;
            r_sh <= 9'd8;
            r_ox <= 8'd0;
            r_oy <= 8'd0;
            r_iw <= 9'd256;
            r_ih <= 9'd256;
            r_fx <= 1'b0;
            r_fy <= 1'b0;
            r_map_valid <= 1'b0;
            r_map_cols <= '0;
            r_map_rows <= '0;
            r_map_n <= '0;
            r_distinct <= '0;
            r_ov <= 1'b0;
            r_issue <= 1'b0;
            r_pv <= 1'b0;
        end else begin
            r_state <= n_state;
            r_map_valid <= n_map_valid;
            r_map_cols <= n_map_cols;
            r_map_rows <= n_map_rows;
            r_map_n <= n_map_n;
            r_distinct <= n_distinct;
            r_ov <= n_ov;
            r_issue <= n_issue;
            r_pv <= n_pv;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SNAP_W: r_sw <= i_cfg_wdata;
                    CFG_SNAP_H: r_sh <= i_cfg_wdata;
                    CFG_OFF_X:  r_ox <= i_cfg_wdata[7:0];
                    CFG_OFF_Y:  r_oy <= i_cfg_wdata[7:0];
                    CFG_IMG_W:  r_iw <= i_cfg_wdata;
                    CFG_IMG_H:  r_ih <= i_cfg_wdata;
                    CFG_FLIP_X: r_fx <= i_cfg_wdata[0];
                    CFG_FLIP_Y: r_fy <= i_cfg_wdata[0];
                    default:    r_fy <= r_fy;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cols <= n_cols;
        r_rows <= n_rows;
        r_prod <= n_prod;
        r_n <= n_n;
        r_t <= n_t;
        r_r <= n_r;
        r_count <= n_count;
        r_tcol <= n_tcol;
        r_tx <= n_tx;
        r_ty <= n_ty;
        r_rcol <= n_rcol;
        r_rx <= n_rx;
        r_ry <= n_ry;
        r_mode <= n_mode;
        r_flipr <= n_flipr;
        r_last <= n_last;
        r_cx <= n_cx;
        r_cy <= n_cy;
        r_plast <= n_plast;
        r_qok <= n_qok;
        r_o_status <= n_o_status;
        r_o_unique <= n_o_unique;
        r_o_across <= n_o_across;
        r_o_down <= n_o_down;
        r_o_next <= n_o_next;
        r_o_prev <= n_o_prev;
        r_o_flip <= n_o_flip;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {3'b000, r_o_flip, r_o_prev, r_o_next, r_o_down, r_o_across,
                         r_o_unique, r_o_status};

    tdf_div #(.W(9)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    tdf_pix_mem #(.AW(2*SIDE_BITS), .DW(PIXEL_BITS)) u_pix (
        .i_clk     (i_clk),
        .i_we      (pix_we),
        .i_waddr   (pix_waddr),
        .i_wdata   (PIXEL_BITS'(s_pv)),
        .i_raddr_a (pix_raddr_a),
        .i_raddr_b (pix_raddr_b),
        .o_rdata_a (pix_qa),
        .o_rdata_b (pix_qb)
    );

    tdf_link_mem #(.DEPTH(LINK_DEPTH), .AW(TW)) u_link (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_next  (lk_next_d),
        .i_prev  (lk_prev_d),
        .i_flip  (lk_flip_d),
        .i_raddr (lk_raddr),
        .o_next  (lk_next_q),
        .o_prev  (lk_prev_q),
        .o_flip  (lk_flip_q)
    );

    // a join only links a tile to an earlier, eligible reference
    a_join_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_J1) |-> ((CW'(r_last) <= r_r) && (r_r < r_t)))
        else $error("join links out of raster order");

    // tiles 0..t-1 hold at most t distinct rings
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RRD) |-> ((r_count <= r_t) && (r_t < r_n)))
        else $error("unique count exceeds visited tiles");

    // the divider only finishes while the grid size is being worked out
    a_div_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> ((r_state == S_DIVC) || (r_state == S_DIVR)))
        else $error("divider finished outside grid sizing");

endmodule

@@ src/tdf_div.sv @@
`timescale 1ns / 1ps
module tdf_div
    import tdf_pkg::*;
#(
    parameter int W = 9
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_dvs;
    logic             r_done;
    logic [W:0]       trial;
    logic             fits;

    assign trial = {r_rem, r_quo[W-1]};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle, restoring
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? W'(trial - {1'b0, r_dvs}) : trial[W-1:0];
            r_quo <= {r_quo[W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ src/tdf_pix_mem.sv @@
`timescale 1ns / 1ps
module tdf_pix_mem
    import tdf_pkg::*;
#(
    parameter int AW = 16,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] mem [0:(1<<AW)-1];

    always_ff @(posedge i_clk) begin
        if (i_we)
            mem[i_waddr] <= i_wdata;
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

@@ src/tdf_link_mem.sv @@
`timescale 1ns / 1ps
module tdf_link_mem
    import tdf_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  t_link_we      i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [AW-1:0] i_next,
    input  logic [AW-1:0] i_prev,
    input  logic [1:0]    i_flip,
    input  logic [AW-1:0] i_raddr,
    output logic [AW-1:0] o_next,
    output logic [AW-1:0] o_prev,
    output logic [1:0]    o_flip
);

    logic [AW-1:0] next_mem [0:DEPTH-1];
    logic [AW-1:0] prev_mem [0:DEPTH-1];
    logic [1:0]    flip_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we.wr_next)
            next_mem[i_waddr] <= i_next;
        if (i_we.wr_prev)
            prev_mem[i_waddr] <= i_prev;
        if (i_we.wr_flip)
            flip_mem[i_waddr] <= i_flip;
        o_next <= next_mem[i_raddr];
        o_prev <= prev_mem[i_raddr];
        o_flip <= flip_mem[i_raddr];
    end

endmodule

@@ tb/tile_dedup_checker.sv @@
`timescale 1ns / 1ps
module tile_dedup_checker
    import tdf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [55:0] i_m_tdata,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [8:0]  i_cfg_wdata,
    output int          o_pending,
    output int          o_errors,
    output int          o_builds,
    output int          o_queries
);

    typedef struct packed {
        logic [1:0]  status;
        logic [10:0] uniq;
        logic [8:0]  across;
        logic [8:0]  down;
        logic [9:0]  nxt;
        logic [9:0]  prv;
        logic [1:0]  flip;
    } t_tile_result;

    t_tile_result results_due[$];

    logic [7:0] pix_mem[0:65535];
    int         ring_next[0:1023];
    int         ring_prev[0:1023];
    logic [1:0] ring_flip[0:1023];
    int         distinct_cnt, map_cols, map_rows;
    bit         map_ok;
    int         snap_w, snap_h, off_x, off_y, img_w, img_h;
    bit         flip_x_en, flip_y_en;
    int         tile_w, tile_h;

    function automatic int pixel_at(int x, int y);
        int a;
        a = y * 256 + x;
        return (a < 65536) ? int'(pix_mem[a]) : 0;
    endfunction

    function automatic bit tiles_equal(int rx, int ry, int tx, int ty, logic [1:0] mode);
        int bx, by;
        for (int y = 0; y < tile_h; y++) begin
            by = (mode & MIRROR_V) ? tile_h - 1 - y : y;
            for (int x = 0; x < tile_w; x++) begin
                bx = (mode & MIRROR_H) ? tile_w - 1 - x : x;
                if (pixel_at(rx + x, ry + y) != pixel_at(tx + bx, ty + by))
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // link the tile in front of the first eligible earlier tile it equals
    function automatic bit join_ring(int t, logic [1:0] mode, int cols);
        int tx, ty, last;
        tx = (t % cols) * tile_w + off_x;
        ty = (t / cols) * tile_h + off_y;
        for (int r = 0; r < t; r++) begin
            if (ring_prev[r] > r)
                continue;
            if (tiles_equal((r % cols) * tile_w + off_x, (r / cols) * tile_h + off_y,
                            tx, ty, mode)) begin
                last = ring_prev[r];
                ring_prev[t] = last;
                ring_next[t] = r;
                ring_flip[t] = ring_flip[r] ^ mode;
                ring_prev[r] = t;
                ring_next[last] = t;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit build_rings();
        int iw, ih, cols, rows, n, cnt;
        iw = (img_w > 256) ? 256 : img_w;
        ih = (img_h > 256) ? 256 : img_h;
        map_ok = 1'b0;
        map_cols = 0;
        map_rows = 0;
        distinct_cnt = 0;
        if (snap_w == 0 || snap_h == 0 || iw <= off_x || ih <= off_y)
            return 1'b0;
        cols = (iw - off_x) / snap_w;
        rows = (ih - off_y) / snap_h;
        if (cols < 1 || rows < 1 || cols * rows > 1024)
            return 1'b0;
        n = cols * rows;
        tile_w = snap_w;
        tile_h = snap_h;
        for (int t = 0; t < n; t++) begin
            ring_prev[t] = t;
            ring_next[t] = t;
            ring_flip[t] = TILE_NO_FLIP;
        end
        cnt = 1;
        for (int t = 1; t < n; t++) begin
            if (join_ring(t, TILE_NO_FLIP, cols))
                continue;
            if (flip_y_en && join_ring(t, MIRROR_V, cols))
                continue;
            if (flip_x_en && join_ring(t, MIRROR_H, cols))
                continue;
            if (flip_x_en && flip_y_en && join_ring(t, MIRROR_HV, cols))
                continue;
            cnt++;
        end
        map_cols = cols;
        map_rows = rows;
        distinct_cnt = cnt;
        map_ok = 1'b1;
        return 1'b1;
    endfunction

    function automatic t_tile_result predict_result(logic [1:0] req, logic [39:0] d);
        t_tile_result res;
        int ti;
        res = '0;
        ti = int'(d[33:24]);
        case (req)
            REQ_LOAD: pix_mem[int'(d[15:8]) * 256 + int'(d[7:0])] = d[23:16];
            REQ_BUILD: res.status = build_rings() ? ST_OK : ST_FAIL;
            REQ_QUERY: begin
                if (map_ok && ti < map_cols * map_rows) begin
                    res.nxt = ring_next[ti][9:0];
                    res.prv = ring_prev[ti][9:0];
                    res.flip = ring_flip[ti];
                end else begin
                    res.status = ST_BADQ;
                end
            end
            default: ;
        endcase
        res.uniq = distinct_cnt[10:0];
        res.across = map_cols[8:0];
        res.down = map_rows[8:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_tile_result want, got;
        if (!i_rst_n) begin
            results_due.delete();
            for (int i = 0; i < 65536; i++)
                pix_mem[i] = '0;
            distinct_cnt = 0;
            map_cols = 0;
            map_rows = 0;
            map_ok = 1'b0;
            snap_w = 8;
            snap_h = 8;
            off_x = 0;
            off_y = 0;
            img_w = 256;
            img_h = 256;
            flip_x_en = 1'b0;
            flip_y_en = 1'b0;
            tile_w = 8;
            tile_h = 8;
            o_errors <= 0;
            o_builds <= 0;
            o_queries <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.status = i_m_tdata[1:0];
                got.uniq = i_m_tdata[12:2];
                got.across = i_m_tdata[21:13];
                got.down = i_m_tdata[30:22];
                got.nxt = i_m_tdata[40:31];
                got.prv = i_m_tdata[50:41];
                got.flip = i_m_tdata[52:51];
                if (results_due.size() == 0) begin
                    if (o_errors < 10)
                        $display("%0t: unexpected result %h", $time, i_m_tdata);
                    o_errors <= o_errors + 1;
                end else begin
                    want = results_due.pop_front();
                    if (got.status !== want.status || got.uniq !== want.uniq ||
                        got.across !== want.across || got.down !== want.down ||
                        got.nxt !== want.nxt || got.prv !== want.prv ||
                        got.flip !== want.flip) begin
                        if (o_errors < 10) begin
                            $display("%0t: mismatch exp st=%0d uq=%0d ac=%0d dn=%0d nx=%0d pv=%0d fl=%0d",
                                     $time, want.status, want.uniq, want.across, want.down,
                                     want.nxt, want.prv, want.flip);
                            $display("%0t: mismatch got st=%0d uq=%0d ac=%0d dn=%0d nx=%0d pv=%0d fl=%0d",
                                     $time, got.status, got.uniq, got.across, got.down,
                                     got.nxt, got.prv, got.flip);
                        end
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SNAP_W: snap_w = int'(i_cfg_wdata);
                    CFG_SNAP_H: snap_h = int'(i_cfg_wdata);
                    CFG_OFF_X:  off_x = int'(i_cfg_wdata[7:0]);
                    CFG_OFF_Y:  off_y = int'(i_cfg_wdata[7:0]);
                    CFG_IMG_W:  img_w = int'(i_cfg_wdata);
                    CFG_IMG_H:  img_h = int'(i_cfg_wdata);
                    CFG_FLIP_X: flip_x_en = i_cfg_wdata[0];
                    CFG_FLIP_Y: flip_y_en = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                results_due.push_back(predict_result(i_s_tuser, i_s_tdata));
                if (i_s_tuser == REQ_BUILD)
                    o_builds <= o_builds + 1;
                if (i_s_tuser == REQ_QUERY)
                    o_queries <= o_queries + 1;
            end
        end
        o_pending <= results_due.size();
    end

endmodule

@@ tb/tile_dedup_with_flips_unit_tb.sv @@
`timescale 1ns / 1ps
module tile_dedup_with_flips_unit_tb;
    import tdf_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = REQ_LOAD;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [55:0] o_m_tdata;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = CFG_SNAP_W;
    logic [8:0]  i_cfg_wdata = '0;

    int pending, errors, builds, queries;
    bit gapless = 1'b0;
    int sink_stall = 0;
    logic [7:0] img[0:65535];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    tile_dedup_with_flips_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata)
    );

    tile_dedup_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .i_m_tdata(o_m_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .o_pending(pending), .o_errors(errors), .o_builds(builds), .o_queries(queries)
    );

    // result side: random stall after each transfer unless gapless
    always @(posedge i_clk) begin
        int stall;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            i_m_tready <= 1'b0;
        end else if (i_m_tready && o_m_tvalid && !gapless) begin
            stall = $urandom_range(0, 17);
            sink_stall <= (stall > 0) ? stall - 1 : 0;
            i_m_tready <= (stall == 0);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    task automatic send(input logic [1:0] req, input int x, input int y, input int v,
                        input int ti);
        int gap;
        gap = gapless ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= req;
        i_s_tdata <= {6'd0, ti[9:0], v[7:0], y[7:0], x[7:0]};
        do @(negedge i_clk); while (!o_s_tready);
        @(posedge i_clk);
    endtask

    task automatic load_px(input int x, input int y, input int v);
        img[y * 256 + x] = v[7:0];
        send(REQ_LOAD, x, y, v, $urandom_range(0, 1023));
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_geometry(input int sw, input int sh, input int ox, input int oy,
                                input int iw, input int ih, input bit fx, input bit fy);
        int vals[8];
        vals = '{sw, sh, ox, oy, iw, ih, int'(fx), int'(fy)};
        drain();
        for (int i = 0; i < 8; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_addr <= i[2:0];
            i_cfg_wdata <= vals[i][8:0];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input int ph);
        int sw, sh, cols, rows, ox, oy, iw, ih, src, mode, sx, sy, k, alpha;
        bit fx, fy;
        sw = $urandom_range(1, 3);
        sh = $urandom_range(1, 3);
        cols = $urandom_range(1, 4);
        rows = $urandom_range(1, 12 / cols);
        ox = $urandom_range(0, 256 - cols * sw);
        oy = $urandom_range(0, 256 - rows * sh);
        iw = ox + cols * sw + $urandom_range(0, sw - 1);
        ih = oy + rows * sh + $urandom_range(0, sh - 1);
        if (iw > 256) iw = 256;
        if (ih > 256) ih = 256;
        fx = (ph < 4) ? ph[0] : $urandom_range(0, 1);
        fy = (ph < 4) ? ph[1] : $urandom_range(0, 1);
        alpha = $urandom_range(1, 3);
        gapless = (ph % 3 == 1);
        set_geometry(sw, sh, ox, oy, iw, ih, fx, fy);
        // fill every tile: fresh content or a copy, possibly mirrored, of an earlier tile
        for (int t = 0; t < cols * rows; t++) begin
            src = (t > 0 && $urandom_range(0, 9) < 6) ? $urandom_range(0, t - 1) : -1;
            mode = $urandom_range(0, 3);
            for (int y = 0; y < sh; y++)
                for (int x = 0; x < sw; x++) begin
                    if (src < 0) begin
                        k = $urandom_range(0, alpha);
                    end else begin
                        sx = ox + (src % cols) * sw + ((mode & 1) ? sw - 1 - x : x);
                        sy = oy + (src / cols) * sh + ((mode & 2) ? sh - 1 - y : y);
                        k = img[sy * 256 + sx];
                    end
                    load_px(ox + (t % cols) * sw + x, oy + (t / cols) * sh + y, k);
                end
        end
        send(REQ_BUILD, 0, 0, 0, 0);
        drain();
        for (int i = 0; i < 60; i++) begin
            k = $urandom_range(0, 99);
            if (k < 45)
                load_px(ox + $urandom_range(0, cols * sw - 1),
                        oy + $urandom_range(0, rows * sh - 1), $urandom_range(0, alpha));
            else if (k < 55)
                load_px($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
            else if (k < 70)
                send(REQ_BUILD, 0, 0, 0, 0);
            else if (k < 95)
                send(REQ_QUERY, 0, 0, 0, ($urandom_range(0, 9) == 0) ?
                     $urandom_range(0, 1023) : $urandom_range(0, cols * rows));
            else
                send(REQ_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 1023));
        end
    endtask

    initial begin
        #20ms;
        $display("tile_dedup_with_flips_unit verification failed");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // no map yet, unknown request, corner pixels
        send(REQ_QUERY, 0, 0, 0, 0);
        send(REQ_UNUSED, 255, 255, 255, 1023);
        load_px(255, 255, 255);
        load_px(0, 0, 0);
        // zero tile size
        set_geometry(0, 8, 0, 0, 256, 256, 1'b1, 1'b1);
        send(REQ_BUILD, 0, 0, 0, 0);
        send(REQ_QUERY, 0, 0, 0, 0);
        // oversized image saturates, a single tile covers everything
        set_geometry(256, 256, 0, 0, 511, 511, 1'b1, 1'b1);
        send(REQ_BUILD, 0, 0, 0, 0);
        send(REQ_QUERY, 0, 0, 0, 0);
        send(REQ_QUERY, 0, 0, 0, 1);
        send(REQ_QUERY, 0, 0, 0, 1023);
        // map keeps its size across a configuration change
        set_geometry(1, 1, 255, 255, 256, 256, 1'b0, 1'b0);
        send(REQ_QUERY, 0, 0, 0, 0);
        send(REQ_BUILD, 0, 0, 0, 0);
        send(REQ_QUERY, 0, 0, 0, 0);
        // too many tiles
        set_geometry(1, 1, 0, 0, 256, 256, 1'b0, 1'b0);
        send(REQ_BUILD, 0, 0, 0, 0);
        // offset beyond the image
        set_geometry(4, 4, 200, 10, 8, 256, 1'b0, 1'b1);
        send(REQ_BUILD, 0, 0, 0, 0);
        set_geometry(4, 4, 0, 200, 256, 8, 1'b1, 1'b0);
        send(REQ_BUILD, 0, 0, 0, 0);
        send(REQ_QUERY, 0, 0, 0, 0);
        for (int ph = 0; ph < 9; ph++)
            run_phase(ph);
        gapless = 1'b0;
        drain();
        $display("covered %0d builds and %0d queries over nine random tile grids",
                 builds, queries);
        $display("plus directed grid-unfit, saturation and single-tile cases");
        if (errors == 0)
            $display("tile_dedup_with_flips_unit verification clean");
        else
            $display("tile_dedup_with_flips_unit verification failed");
        $finish;
    end

endmodule
